// File: src/egsc_pkg.sv
// Shared types, constants and register codes for the exposure/gain code converter.
package egsc_pkg;

	// Datapath widths
	localparam int EXP_W   = 20;
	localparam int GAIN_W  = 24;
	localparam int LINES_W = 16;
	localparam int PCLK_W  = 8;
	localparam int COMP_W  = 32;
	localparam int ACODE_W = 5;
	localparam int DCODE_W = 10;

	// Shared multiplier operand widths
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Shared divider: width and quotient bits retired per cycle
	localparam int DIV_W         = 32;
	localparam int DIV_BITS_STEP = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_LENGTH = 2'd0,
		REG_PIXEL_CLOCK  = 2'd1,
		REG_LINE_LENGTH  = 2'd2
	} cfg_reg_t;

	localparam logic [LINES_W-1:0] FRAME_LENGTH_RST = 16'd1200;
	localparam logic [PCLK_W-1:0]  PIXEL_CLOCK_RST  = 8'd81;
	localparam logic [LINES_W-1:0] LINE_LENGTH_RST  = 16'h0898;

	// Exposure clamp
	localparam int EXP_MIN_LINES = 4;
	localparam int EXP_MARGIN    = 8;

	// Gain mapping (Q10, 1024 = 1x)
	localparam int GAIN_FRAC    = 10;
	localparam int GAIN_UNITY   = 1 << GAIN_FRAC;
	localparam int GAIN_MAX     = 180 * 1024;
	localparam int ANALOG_STEP  = 'h800;
	localparam int ANALOG_STEPS = 5;
	localparam int DIGITAL_CAP  = 4096;

	localparam logic [ACODE_W-1:0] ANALOG_MAP [ANALOG_STEPS+1] =
		'{5'h00, 5'h08, 5'h09, 5'h0b, 5'h0f, 5'h1f};

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

// File: src/egsc_in_if.sv
// Request channel: exposure time and total gain.
interface egsc_in_if import egsc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [EXP_W-1:0]  exposure_us;
	logic [GAIN_W-1:0] total_gain;

	modport source (output valid, output exposure_us, output total_gain, input ready);
	modport sink   (input valid, input exposure_us, input total_gain, output ready);
endinterface

// File: src/egsc_out_if.sv
// Result channel: sensor exposure lines, gain codes and change flags.
interface egsc_out_if import egsc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LINES_W-1:0] exposure_lines;
	logic [COMP_W-1:0]  compensated_gain;
	logic [ACODE_W-1:0] analog_code;
	logic [DCODE_W-1:0] digital_code;
	logic               exposure_changed;
	logic               analog_changed;
	logic               digital_changed;

	modport source (
		output valid, output exposure_lines, output compensated_gain, output analog_code,
		output digital_code, output exposure_changed, output analog_changed,
		output digital_changed, input ready
	);
	modport sink (
		input valid, input exposure_lines, input compensated_gain, input analog_code,
		input digital_code, input exposure_changed, input analog_changed,
		input digital_changed, output ready
	);
endinterface

// File: src/exposure_gain_to_sensor_codes.sv
// Top level: exposure time and gain to sensor exposure lines and gain codes.
//
// Each request (exposure in microseconds, Q10 total gain) is turned into sensor exposure
// lines clamped to [4, frame_length_lines - 8], a shortfall-compensated gain saturated at
// 32 bits, an analog gain code, a digital gain code and three change flags against the
// previous result. One request is in work at a time; request.ready is high only while the
// sequencer is idle. A request makes up to three passes through one shared divider that
// retires two quotient bits a cycle while busy, and a division is skipped on zero line
// length, zero pixel clock, or no shortfall. It also uses the shared 24x16 multiplier in
// S_MUL1, S_MUL2, S_MUL3_LO and S_MUL3_HI, accumulates in S_ACCUM and maps the codes in
// S_FINISH, where it waits for a free output register before it returns to idle. The
// result sits in an output register, so the next request is accepted while a result waits
// to be taken. The user must see that registers are written through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce it. Indexes
// beyond the three registers are ignored.
module exposure_gain_to_sensor_codes import egsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	egsc_in_if.sink               request,
	egsc_out_if.source            result
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_DIV1_START, S_DIV1_WAIT, S_MUL2, S_DIV2_START, S_DIV2_WAIT,
		S_DIV3_START, S_DIV3_WAIT, S_MUL3_LO, S_MUL3_HI, S_ACCUM, S_FINISH
	} state_t;

	typedef struct packed {
		logic [ACODE_W-1:0] acode;
		logic [DCODE_W-1:0] dcode;
	} codes_t;

	localparam int RatioW = EXP_W + GAIN_FRAC;
	localparam int SumW   = MUL_P_W + MUL_B_W;

	// Clamp gain to [1x, 180x], take up to five 2x analog steps, cap the rest and
	// split it into coarse doubling bits and an 8-bit fine part.
	function automatic codes_t gain_codes(input logic [COMP_W-1:0] comp);
		logic [17:0] g;
		logic [2:0]  steps;
		logic [17:0] h;
		logic [12:0] d;
		logic [1:0]  coarse;
		logic [7:0]  fine;
		codes_t      c;
		if (comp < COMP_W'(GAIN_UNITY))
			g = 18'(GAIN_UNITY);
		else if (comp > COMP_W'(GAIN_MAX))
			g = 18'(GAIN_MAX);
		else
			g = comp[17:0];
		steps = '0;
		for (int k = 0; k < ANALOG_STEPS; k++) begin
			if (g >= (18'(ANALOG_STEP) << k))
				steps = steps + 3'd1;
		end
		h = g >> steps;
		if (h > 18'(DIGITAL_CAP))
			d = 13'(DIGITAL_CAP);
		else
			d = h[12:0];
		if (d[12]) begin
			// at the cap: two doublings leave exactly 1x
			coarse = 2'd3;
			fine   = 8'(GAIN_UNITY >> 3);
		end else if (d[11]) begin
			coarse = 2'd1;
			fine   = d[11:4];
		end else begin
			coarse = 2'd0;
			fine   = d[10:3];
		end
		c.acode = ANALOG_MAP[steps];
		c.dcode = {coarse, fine};
		return c;
	endfunction

	state_t              state_q;
	logic [LINES_W-1:0]  fll_q, llc_q;
	logic [PCLK_W-1:0]   pclk_q;
	logic [EXP_W-1:0]    exp_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [LINES_W-1:0]  lines_q;
	logic [RatioW-1:0]   ratio_q;
	logic [MUL_P_W-1:0]  acc_q;
	logic [COMP_W-1:0]   comp_q;
	logic [LINES_W-1:0]  last_lines_q;
	logic [ACODE_W-1:0]  last_acode_q;
	logic [DCODE_W-1:0]  last_dcode_q;

	logic                out_valid_q;
	logic [LINES_W-1:0]  out_lines_q;
	logic [COMP_W-1:0]   out_comp_q;
	logic [ACODE_W-1:0]  out_acode_q;
	logic [DCODE_W-1:0]  out_dcode_q;
	logic                out_exp_chg_q, out_ana_chg_q, out_dig_chg_q;

	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  mul_p;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic [LINES_W-1:0]  limit;
	logic [DIV_W-1:0]    lines_sel;
	logic                short_exp;
	logic [SumW-1:0]     sum;
	logic                out_free;
	codes_t              codes;

	// upper exposure bound, zero when the frame is shorter than the margin
	assign limit = (fll_q >= LINES_W'(EXP_MARGIN)) ? fll_q - LINES_W'(EXP_MARGIN) : '0;

	always_comb begin
		lines_sel = div_rsp.quot;
		if (lines_sel < DIV_W'(EXP_MIN_LINES))
			lines_sel = DIV_W'(EXP_MIN_LINES);
		if (lines_sel > DIV_W'(limit))
			lines_sel = DIV_W'(limit);
	end

	// recomputed time is nonzero and falls short of the request
	assign short_exp = (div_rsp.quot != '0) && (div_rsp.quot < DIV_W'(exp_q));

	// gain * ratio from two partial products
	assign sum = SumW'(acc_q) + (SumW'(mul_p) << MUL_B_W);

	assign out_free = !out_valid_q || result.ready;
	assign codes    = gain_codes(comp_q);

	// operand select for the shared units
	always_comb begin
		mul_a       = MUL_A_W'(exp_q);
		mul_b       = MUL_B_W'(pclk_q);
		div_req     = '0;
		div_req.num = DIV_W'(mul_p[DIV_W-1:0]);
		div_req.den = DIV_W'(llc_q);
		unique case (state_q)
			S_MUL2: begin
				mul_a = MUL_A_W'(lines_q);
				mul_b = llc_q;
			end
			S_MUL3_LO: begin
				mul_a = gain_q;
				mul_b = ratio_q[MUL_B_W-1:0];
			end
			S_MUL3_HI: begin
				mul_a = gain_q;
				mul_b = MUL_B_W'(ratio_q[RatioW-1:MUL_B_W]);
			end
			S_DIV1_START: begin
				div_req.start = (llc_q != '0);
			end
			S_DIV2_START: begin
				div_req.start = (pclk_q != '0);
				div_req.den   = DIV_W'(pclk_q);
			end
			S_DIV3_START: begin
				div_req.start = short_exp;
				div_req.num   = DIV_W'({exp_q, {GAIN_FRAC{1'b0}}});
				div_req.den   = div_rsp.quot;
			end
			default: begin
			end
		endcase
	end

	egsc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	egsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fll_q        <= FRAME_LENGTH_RST;
			pclk_q       <= PIXEL_CLOCK_RST;
			llc_q        <= LINE_LENGTH_RST;
			last_lines_q <= '1;
			last_acode_q <= '1;
			last_dcode_q <= '1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_LENGTH: fll_q  <= cfg_data;
					REG_PIXEL_CLOCK:  pclk_q <= cfg_data[PCLK_W-1:0];
					REG_LINE_LENGTH:  llc_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			if (result.ready && !(state_q == S_FINISH && out_free))
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						exp_q   <= request.exposure_us;
						gain_q  <= request.total_gain;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_DIV1_START;
				S_DIV1_START: begin
					if (llc_q == '0) begin
						// line quotient saturates: exposure sits at the upper bound
						lines_q <= limit;
						state_q <= S_MUL2;
					end else begin
						state_q <= S_DIV1_WAIT;
					end
				end
				S_DIV1_WAIT: begin
					if (div_rsp.done) begin
						lines_q <= lines_sel[LINES_W-1:0];
						state_q <= S_MUL2;
					end
				end
				S_MUL2: state_q <= S_DIV2_START;
				S_DIV2_START: begin
					if (pclk_q == '0) begin
						// recomputed time saturates: no shortfall
						ratio_q <= RatioW'(GAIN_UNITY);
						state_q <= S_MUL3_LO;
					end else begin
						state_q <= S_DIV2_WAIT;
					end
				end
				S_DIV2_WAIT: begin
					if (div_rsp.done)
						state_q <= S_DIV3_START;
				end
				S_DIV3_START: begin
					if (short_exp) begin
						state_q <= S_DIV3_WAIT;
					end else begin
						ratio_q <= RatioW'(GAIN_UNITY);
						state_q <= S_MUL3_LO;
					end
				end
				S_DIV3_WAIT: begin
					if (div_rsp.done) begin
						ratio_q <= div_rsp.quot[RatioW-1:0];
						state_q <= S_MUL3_LO;
					end
				end
				S_MUL3_LO: state_q <= S_MUL3_HI;
				S_MUL3_HI: begin
					acc_q   <= mul_p;
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					if (sum[SumW-1:COMP_W+GAIN_FRAC] != '0)
						comp_q <= '1;
					else
						comp_q <= sum[COMP_W+GAIN_FRAC-1:GAIN_FRAC];
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_lines_q   <= lines_q;
						out_comp_q    <= comp_q;
						out_acode_q   <= codes.acode;
						out_dcode_q   <= codes.dcode;
						out_exp_chg_q <= (lines_q != last_lines_q);
						out_ana_chg_q <= (codes.acode != last_acode_q);
						out_dig_chg_q <= (codes.dcode != last_dcode_q);
						last_lines_q  <= lines_q;
						last_acode_q  <= codes.acode;
						last_dcode_q  <= codes.dcode;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign request.ready           = (state_q == S_IDLE);
	assign result.valid            = out_valid_q;
	assign result.exposure_lines   = out_lines_q;
	assign result.compensated_gain = out_comp_q;
	assign result.analog_code      = out_acode_q;
	assign result.digital_code     = out_dcode_q;
	assign result.exposure_changed = out_exp_chg_q;
	assign result.analog_changed   = out_ana_chg_q;
	assign result.digital_changed  = out_dig_chg_q;

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
	a_lines_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL2) |-> (lines_q <= limit)) else $error("exposure lines above limit");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> (state_q == S_MUL1))
		else $error("accepted request did not start the sequence");

endmodule

// File: src/egsc_mul.sv
// Shared 24x16 unsigned multiplier with registered product.
module egsc_mul import egsc_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// File: src/egsc_div.sv
// Shared restoring divider, several quotient bits per cycle.
module egsc_div import egsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int Steps = DIV_W / DIV_BITS_STEP;
	localparam int CntW  = (Steps > 1) ? $clog2(Steps) : 1;

	logic [DIV_W-1:0] quo_q, den_q, rem_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W-1:0] quo_n, rem_n;

	always_comb begin
		logic [DIV_W:0] t;
		quo_n = quo_q;
		rem_n = rem_q;
		for (int i = 0; i < DIV_BITS_STEP; i++) begin
			t     = {rem_n, quo_n[DIV_W-1]};
			quo_n = {quo_n[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t        = t - {1'b0, den_q};
				quo_n[0] = 1'b1;
			end
			rem_n = t[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntW'(Steps - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider did not go busy after start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == CntW'(Steps - 1)) |=> done_q)
		else $error("divider missed done after last step");

endmodule
